[design/bhfso_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bhfso_pkg
// Shared widths, types and helpers for the byte histogram core.
// ============================================================================
package bhfso_pkg;

   localparam int COUNT_BITS = 8;              // per-byte counter width, 7..16
   localparam int SYM_BITS   = 8;
   localparam int SYM_DEPTH  = 1 << SYM_BITS;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // count store control
   typedef struct packed {
      logic                  clear;
      logic                  rd_en;
      logic [SYM_BITS-1:0]   rd_addr;
      logic                  wr_en;
      logic [SYM_BITS-1:0]   wr_addr;
      logic [COUNT_BITS-1:0] wr_data;
   } cnt_ctl_type;

   // order list control
   typedef struct packed {
      logic                clear;
      logic                rd_en;
      logic [SYM_BITS-1:0] rd_addr;
      logic                append;
      logic [SYM_BITS-1:0] append_sym;
   } list_ctl_type;

   // report a count capped to eight bits
   function automatic logic [7:0] cap_count(input logic [COUNT_BITS-1:0] c);
      logic [15:0] wide;
      wide = 16'(c);
      return (wide > 16'd255) ? 8'hFF : wide[7:0];
   endfunction

endpackage
`default_nettype wire

[design/bhfso_count_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bhfso_count_store
// Per-byte count memory with a valid mark per entry; a clear drops all marks at once.
// ============================================================================
module bhfso_count_store (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bhfso_pkg::cnt_ctl_type        ctl,
   output logic [bhfso_pkg::COUNT_BITS-1:0]   rd_count,   // 0 when unmarked
   output logic                               rd_hit
);
   import bhfso_pkg::*;

   logic [COUNT_BITS-1:0] count_mem [SYM_DEPTH];
   logic [COUNT_BITS-1:0] count_rd_ff;
   logic [SYM_DEPTH-1:0]  mark_ff;
   logic [SYM_DEPTH-1:0]  mark_in;
   logic                  hit_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         count_mem[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         count_rd_ff <= count_mem[ctl.rd_addr];
         hit_rd_ff   <= mark_ff[ctl.rd_addr];
      end
   end

   always_comb begin
      mark_in = mark_ff;
      if (ctl.clear) begin
         mark_in = '0;
      end else if (ctl.wr_en) begin
         mark_in[ctl.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_ff <= '0;
      end else begin
         mark_ff <= mark_in;
      end
   end

   assign rd_hit   = hit_rd_ff;
   assign rd_count = hit_rd_ff ? count_rd_ff : '0;

endmodule
`default_nettype wire

[design/bhfso_order_list.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// bhfso_order_list
// First-seen order memory and the distinct byte counter.
// ============================================================================
module bhfso_order_list (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire bhfso_pkg::list_ctl_type     ctl,
   output logic [bhfso_pkg::SYM_BITS-1:0]   rd_symbol,
   output logic [bhfso_pkg::SYM_BITS-1:0]   distinct_total
);
   import bhfso_pkg::*;

   logic [SYM_BITS-1:0] list_mem [SYM_DEPTH];
   logic [SYM_BITS-1:0] list_rd_ff;
   logic [SYM_BITS-1:0] distinct_ff;
   logic [SYM_BITS-1:0] distinct_in;

   always_ff @(posedge clock) begin
      if (ctl.append) begin
         list_mem[distinct_ff] <= ctl.append_sym;
      end
      if (ctl.rd_en) begin
         list_rd_ff <= list_mem[ctl.rd_addr];
      end
   end

   always_comb begin
      distinct_in = distinct_ff;
      if (ctl.clear) begin
         distinct_in = '0;
      end else if (ctl.append) begin
         distinct_in = distinct_ff + SYM_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         distinct_ff <= '0;
      end else begin
         distinct_ff <= distinct_in;
      end
   end

   assign rd_symbol      = list_rd_ff;
   assign distinct_total = distinct_ff;

endmodule
`default_nettype wire

[design/byte_histogram_first_seen_order_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// byte_histogram_first_seen_order_core
// Byte histogram that also keeps the order in which distinct bytes first
// appeared; requests clear, count a byte, or read one order-list position.
// ============================================================================
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  req     | in  | req_valid/stall    | kind, symbol, entry_index
//  rsp     | out | rsp_valid/stall    | entry_symbol, entry_count,
//          |     |                    | distinct_total, entry_valid
//
//  Clear, byte-zero add and unused kinds finish in ST_IDLE; an add passes
//  ST_ADD (count read, then write back); a read passes ST_LIST and ST_RESP
//  (list read, count read, response load). One request is in flight at a
//  time, set by the read-modify-write of the count memory, which has no forwarding.
//  Reset clears the valid marks, the distinct counter and the control state;
//  the memories themselves are never swept.
//  A stalled response holds in the output register; the next request is still
//  taken, and a read waits in its last step only until that register frees.
// ============================================================================
module byte_histogram_first_seen_order_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_symbol,
   input  wire logic [7:0]  req_entry_index,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_entry_symbol,
   output logic [7:0]       rsp_entry_count,
   output logic [7:0]       rsp_distinct_total,
   output logic             rsp_entry_valid
);
   import bhfso_pkg::*;

   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_ADD   = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,   // take a request
      ST_ADD  = 4'b0010,   // count read done, write back
      ST_LIST = 4'b0100,   // list entry read done, read its count
      ST_RESP = 4'b1000    // count read done, load response
   } state_type;

   state_type state_ff, state_in;

   logic                  req_take;
   logic                  rsp_load;
   cnt_ctl_type           cnt_ctl;
   list_ctl_type          list_ctl;
   logic [COUNT_BITS-1:0] cnt_rd_count;
   logic                  cnt_rd_hit;
   logic [SYM_BITS-1:0]   list_rd_symbol;
   logic [SYM_BITS-1:0]   distinct_total;

   // request payload held while the request is worked on
   logic [SYM_BITS-1:0]   sym_ff, sym_in;
   logic                  idx_ok_ff, idx_ok_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_symbol_ff, rsp_symbol_in;
   logic [7:0]            rsp_count_ff, rsp_count_in;
   logic [7:0]            rsp_total_ff, rsp_total_in;
   logic                  rsp_ok_ff, rsp_ok_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   // output register can take a new response when empty or draining
   assign rsp_load  = (state_ff == ST_RESP) && (!rsp_valid_ff || !rsp_stall);

   bhfso_count_store u_count_store (
      .clock    (clock),
      .reset    (reset),
      .ctl      (cnt_ctl),
      .rd_count (cnt_rd_count),
      .rd_hit   (cnt_rd_hit)
   );

   bhfso_order_list u_order_list (
      .clock          (clock),
      .reset          (reset),
      .ctl            (list_ctl),
      .rd_symbol      (list_rd_symbol),
      .distinct_total (distinct_total)
   );

   // --------------------------------------------------------------------------
   // sequencer and memory control
   // --------------------------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      sym_in    = sym_ff;
      idx_ok_in = idx_ok_ff;
      cnt_ctl   = '0;
      list_ctl  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_kind)
                  KIND_CLEAR: begin
                     cnt_ctl.clear  = 1'b1;
                     list_ctl.clear = 1'b1;
                  end
                  KIND_ADD: begin
                     // byte zero is a string terminator: ignored
                     if (req_symbol != '0) begin
                        cnt_ctl.rd_en   = 1'b1;
                        cnt_ctl.rd_addr = req_symbol;
                        sym_in          = req_symbol;
                        state_in        = ST_ADD;
                     end
                  end
                  KIND_READ: begin
                     list_ctl.rd_en   = 1'b1;
                     list_ctl.rd_addr = req_entry_index;
                     idx_ok_in        = (req_entry_index < distinct_total);
                     state_in         = ST_LIST;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADD: begin
            cnt_ctl.wr_en   = 1'b1;
            cnt_ctl.wr_addr = sym_ff;
            if (!cnt_rd_hit) begin
               // first sighting since clear: start at one and append
               cnt_ctl.wr_data     = COUNT_BITS'(1);
               list_ctl.append     = 1'b1;
               list_ctl.append_sym = sym_ff;
            end else if (cnt_rd_count == COUNT_MAX) begin
               cnt_ctl.wr_data = cnt_rd_count;
            end else begin
               cnt_ctl.wr_data = cnt_rd_count + COUNT_BITS'(1);
            end
            state_in = ST_IDLE;
         end
         ST_LIST: begin
            cnt_ctl.rd_en   = 1'b1;
            cnt_ctl.rd_addr = list_rd_symbol;
            state_in        = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // --------------------------------------------------------------------------
   // response register; past the list end reports zeros
   // --------------------------------------------------------------------------
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_ok_in     = rsp_ok_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_symbol_in = idx_ok_ff ? list_rd_symbol : 8'd0;
         rsp_count_in  = idx_ok_ff ? cap_count(cnt_rd_count) : 8'd0;
         rsp_total_in  = distinct_total;
         rsp_ok_in     = idx_ok_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff        <= sym_in;
      idx_ok_ff     <= idx_ok_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_ok_ff     <= rsp_ok_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_entry_symbol   = rsp_symbol_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_distinct_total = rsp_total_ff;
   assign rsp_entry_valid    = rsp_ok_ff;

endmodule
`default_nettype wire
